// ===== rtl/core/bbrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// bbrgb_pkg
// Shared types, constants and helpers of the RGB box blur core.
// ----------------------------------------------------------------------------
package bbrgb_pkg;

    // default store geometry and largest radius
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_RADIUS_DEF = 31;

    // fixed field widths
    localparam int CHAN_W = 8;    // one color channel
    localparam int POS_W  = 8;    // pos_x / pos_y
    localparam int DIM_W  = 9;    // frame_width / frame_height register
    localparam int KRAD_W = 5;    // kernel_radius register
    localparam int RAD_W  = 6;    // saturated radius (largest radius 31)
    localparam int CRD_W  = 10;   // internal coordinate, holds up to 255 + 63 and 511
    localparam int IDX_W  = 2;    // config register index
    localparam int PIX_W  = 3 * CHAN_W;

    // config register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_KERNEL_RADIUS = 2'd2;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status codes
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_OUTSIDE   = 1'b1;

    // reset values of the config registers
    localparam logic [DIM_W-1:0]  FRAME_DIM_RST = 9'd256;
    localparam logic [KRAD_W-1:0] RADIUS_RST    = 5'd27;

    // divider result handed back to the sequencer
    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] q_blue;
        logic [CHAN_W-1:0] q_green;
        logic [CHAN_W-1:0] q_red;
    } t_div_res;

    // dimension register value: zero reads as one, large values saturate
    function automatic logic [CRD_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int lim);
        logic [CRD_W-1:0] res;
        res = {1'b0, v};
        if (v == '0) begin
            res = CRD_W'(1);
        end else if (int'(v) > lim) begin
            res = CRD_W'(lim);
        end
        return res;
    endfunction

    // radius register value saturated to the largest radius
    function automatic logic [RAD_W-1:0] clamp_rad(input logic [KRAD_W-1:0] v,
                                                   input int lim);
        logic [RAD_W-1:0] res;
        res = {1'b0, v};
        if (int'(v) > lim) begin
            res = RAD_W'(lim);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/bbrgb_if.sv =====
// ----------------------------------------------------------------------------
// bbrgb_if
// Channel interfaces of the RGB box blur core: input, result and config.
// ----------------------------------------------------------------------------

// pixel write / query requests
interface bbrgb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [bbrgb_pkg::POS_W-1:0]  pos_x;
    logic [bbrgb_pkg::POS_W-1:0]  pos_y;
    logic [bbrgb_pkg::CHAN_W-1:0] in_blue;
    logic [bbrgb_pkg::CHAN_W-1:0] in_green;
    logic [bbrgb_pkg::CHAN_W-1:0] in_red;

    modport source (output valid, operation, pos_x, pos_y, in_blue, in_green, in_red,
                    input ready);
    modport sink   (input valid, operation, pos_x, pos_y, in_blue, in_green, in_red,
                    output ready);
endinterface

// blurred pixel results
interface bbrgb_out_if;
    logic                        valid;
    logic                        ready;
    logic [bbrgb_pkg::CHAN_W-1:0] out_blue;
    logic [bbrgb_pkg::CHAN_W-1:0] out_green;
    logic [bbrgb_pkg::CHAN_W-1:0] out_red;
    logic                        status;

    modport source (output valid, out_blue, out_green, out_red, status, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, status, output ready);
endinterface

// config register writes
interface bbrgb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bbrgb_pkg::IDX_W-1:0]  index;
    logic [bbrgb_pkg::DIM_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bbrgb_store.sv =====
// ----------------------------------------------------------------------------
// bbrgb_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbrgb_store #(
    parameter int DEPTH  = bbrgb_pkg::MAX_WIDTH_DEF * bbrgb_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic [bbrgb_pkg::PIX_W-1:0]   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    output logic [bbrgb_pkg::PIX_W-1:0]   o_rd_data
);

    logic [bbrgb_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [bbrgb_pkg::PIX_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/bbrgb_div.sv =====
// ----------------------------------------------------------------------------
// bbrgb_div
// Restoring divider shared by the three channels, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bbrgb_div #(
    parameter int CNT_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [CNT_W+7:0]            i_sum_blue,
    input  logic [CNT_W+7:0]            i_sum_green,
    input  logic [CNT_W+7:0]            i_sum_red,
    input  logic [CNT_W-1:0]            i_count,
    output bbrgb_pkg::t_div_res         o_res
);

    localparam int SUM_W = CNT_W + 8;
    localparam int BIT_W = $clog2(bbrgb_pkg::CHAN_W);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(bbrgb_pkg::CHAN_W - 1);
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    logic                          r_busy;
    logic                          r_done;
    logic [1:0]                    r_ch;
    logic [BIT_W-1:0]              r_bit;
    logic [SUM_W-1:0]              r_rem;
    logic [SUM_W-1:0]              r_den;
    logic [CNT_W-1:0]              r_count;
    logic [SUM_W-1:0]              r_sum_g;
    logic [SUM_W-1:0]              r_sum_r;
    logic [bbrgb_pkg::CHAN_W-1:0]  r_q;
    logic [bbrgb_pkg::CHAN_W-1:0]  r_q_b;
    logic [bbrgb_pkg::CHAN_W-1:0]  r_q_g;
    logic [bbrgb_pkg::CHAN_W-1:0]  r_q_r;

    logic                          ge;
    logic [SUM_W-1:0]              den_top;
    logic [bbrgb_pkg::CHAN_W-1:0]  q_next;

    // the shared compare / subtract step
    assign ge      = (r_rem >= r_den);
    assign den_top = SUM_W'(r_count) << (bbrgb_pkg::CHAN_W - 1);
    assign q_next  = {r_q[bbrgb_pkg::CHAN_W-2:0], ge};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ch   <= CH_BLUE;
            r_bit  <= BIT_TOP;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ch   <= CH_BLUE;
                r_bit  <= BIT_TOP;
            end else if (r_busy) begin
                r_bit <= r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    r_bit <= BIT_TOP;
                    if (r_ch == CH_RED) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_sum_blue;
            r_den   <= SUM_W'(i_count) << (bbrgb_pkg::CHAN_W - 1);
            r_count <= i_count;
            r_sum_g <= i_sum_green;
            r_sum_r <= i_sum_red;
            r_q     <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (r_rem - r_den) : r_rem;
            r_den <= r_den >> 1;
            r_q   <= q_next;
            if (r_bit == '0) begin
                // channel finished: store quotient, load the next dividend
                case (r_ch)
                    CH_BLUE: begin
                        r_q_b <= q_next;
                        r_rem <= r_sum_g;
                    end
                    CH_GREEN: begin
                        r_q_g <= q_next;
                        r_rem <= r_sum_r;
                    end
                    default: begin
                        r_q_r <= q_next;
                    end
                endcase
                r_den <= den_top;
            end
        end
    end

    assign o_res.done    = r_done;
    assign o_res.q_blue  = r_q_b;
    assign o_res.q_green = r_q_g;
    assign o_res.q_red   = r_q_r;

endmodule

// ===== rtl/core/box_blur_rgb_clipped_window_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_rgb_clipped_window_core
// Box blur over a stored BGR frame with the window clipped at frame edges.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : write or query requests. A write stores one pixel at (pos_x, pos_y)
//           and gives no result; a write outside the store is dropped.
//   o_out : one result per query: the truncated per-channel mean over the
//           clipped window, or status 1 with zero channels when the query lies
//           outside the frame.
//   i_cfg : frame width, frame height and kernel radius, always ready; write
//           only while no request is in flight.
// Timing:
//   A write leaves ready high.
//   A query holds ready low from its acceptance until its result is loaded:
//   setup, one scan read per pixel of the clipped window (55 x 55 at the reset
//   radius 27, 63 x 63 at radius 31) on the single store port, drain, divider
//   start, the shared divider (blue, green, red, then done) and the output
//   load. The result shows at the same edge at which ready rises again. An
//   outside query skips the scan and the divider.
// Reset clears control and config only; the frame store is undefined until
// written. A finished result waits in the output register while the receiver
// stalls; the next request is taken meanwhile and holds before its output.
// ----------------------------------------------------------------------------
module box_blur_rgb_clipped_window_core #(
    parameter int MAX_WIDTH  = bbrgb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbrgb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = bbrgb_pkg::MAX_RADIUS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bbrgb_in_if.sink         i_in,
    bbrgb_out_if.source      o_out,
    bbrgb_cfg_if.sink        i_cfg
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIN    = 2 * MAX_RADIUS + 1;
    localparam int CNT_W  = (WIN * WIN > 1) ? $clog2(WIN * WIN + 1) : 1;
    localparam int SUM_W  = CNT_W + 8;
    localparam int CRD_W  = bbrgb_pkg::CRD_W;
    localparam int CH_W   = bbrgb_pkg::CHAN_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                 r_state, n_state;

    // config registers, kept saturated
    logic [CRD_W-1:0]           r_w;
    logic [CRD_W-1:0]           r_h;
    logic [bbrgb_pkg::RAD_W-1:0] r_rad;

    // query context
    logic [CRD_W-1:0]           r_x, r_y;
    logic                       r_err;
    logic [CRD_W-1:0]           r_x0, r_x1, r_y1;
    logic [CRD_W-1:0]           r_i, r_j;
    logic [ADDR_W-1:0]          r_base;
    logic                       r_rd_vld;
    logic [SUM_W-1:0]           r_sb, r_sg, r_sr;
    logic [CNT_W-1:0]           r_cnt;

    // output register
    logic                       r_o_vld;
    logic [CH_W-1:0]            r_o_b, r_o_g, r_o_r;
    logic                       r_o_st;

    logic                       in_acc;
    logic                       cfg_acc;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       rd_en;
    logic [bbrgb_pkg::PIX_W-1:0] rd_data;
    logic                       out_free;
    logic [CRD_W-1:0]           y0, y1, x0, x1;
    logic [CRD_W-1:0]           rad_ext;
    logic                       div_start;
    bbrgb_pkg::t_div_res        div_res;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign out_free    = !r_o_vld || o_out.ready;

    // config writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= bbrgb_pkg::clamp_dim(bbrgb_pkg::FRAME_DIM_RST, MAX_WIDTH);
            r_h   <= bbrgb_pkg::clamp_dim(bbrgb_pkg::FRAME_DIM_RST, MAX_HEIGHT);
            r_rad <= bbrgb_pkg::clamp_rad(bbrgb_pkg::RADIUS_RST, MAX_RADIUS);
        end else if (cfg_acc) begin
            case (i_cfg.index)
                bbrgb_pkg::REG_FRAME_WIDTH:
                    r_w <= bbrgb_pkg::clamp_dim(i_cfg.data, MAX_WIDTH);
                bbrgb_pkg::REG_FRAME_HEIGHT:
                    r_h <= bbrgb_pkg::clamp_dim(i_cfg.data, MAX_HEIGHT);
                bbrgb_pkg::REG_KERNEL_RADIUS:
                    r_rad <= bbrgb_pkg::clamp_rad(
                        i_cfg.data[bbrgb_pkg::KRAD_W-1:0], MAX_RADIUS);
                default: ;
            endcase
        end
    end

    // pixel write straight from the request
    assign wr_en   = in_acc && (i_in.operation == bbrgb_pkg::OP_WRITE)
                     && (int'(i_in.pos_x) < MAX_WIDTH) && (int'(i_in.pos_y) < MAX_HEIGHT);
    assign wr_addr = ADDR_W'(ADDR_W'(i_in.pos_y) * ADDR_W'(MAX_WIDTH))
                     + ADDR_W'(i_in.pos_x);

    // clipped window bounds
    assign rad_ext = CRD_W'(r_rad);
    assign y0 = (r_y > rad_ext) ? (r_y - rad_ext) : '0;
    assign x0 = (r_x > rad_ext) ? (r_x - rad_ext) : '0;
    assign y1 = ((r_y + rad_ext) < r_h) ? (r_y + rad_ext) : (r_h - CRD_W'(1));
    assign x1 = ((r_x + rad_ext) < r_w) ? (r_x + rad_ext) : (r_w - CRD_W'(1));

    // scan read port
    assign rd_en   = (r_state == S_SCAN);
    assign rd_addr = r_base + ADDR_W'(r_j);

    bbrgb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_in.in_red, i_in.in_green, i_in.in_blue}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign div_start = (r_state == S_DIVGO);

    bbrgb_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_sum_blue  (r_sb),
        .i_sum_green (r_sg),
        .i_sum_red   (r_sr),
        .i_count     (r_cnt),
        .o_res       (div_res)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.operation == bbrgb_pkg::OP_QUERY)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = r_err ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                if ((r_j == r_x1) && (r_i == r_y1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
        end
    end

    // query context and scan counters
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= CRD_W'(i_in.pos_x);
            r_y   <= CRD_W'(i_in.pos_y);
            r_err <= (CRD_W'(i_in.pos_x) >= r_w) || (CRD_W'(i_in.pos_y) >= r_h);
        end
        case (r_state)
            S_SETUP: begin
                r_x0   <= x0;
                r_x1   <= x1;
                r_y1   <= y1;
                r_i    <= y0;
                r_j    <= x0;
                r_base <= ADDR_W'(ADDR_W'(y0) * ADDR_W'(MAX_WIDTH));
            end
            S_SCAN: begin
                if (r_j == r_x1) begin
                    r_j <= r_x0;
                    if (r_i != r_y1) begin
                        r_i    <= r_i + CRD_W'(1);
                        r_base <= r_base + ADDR_W'(MAX_WIDTH);
                    end
                end else begin
                    r_j <= r_j + CRD_W'(1);
                end
            end
            default: ;
        endcase
    end

    // channel sums and pixel count, one stored pixel a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_sb  <= '0;
            r_sg  <= '0;
            r_sr  <= '0;
            r_cnt <= '0;
        end else if (r_rd_vld) begin
            r_sb  <= r_sb + SUM_W'(rd_data[CH_W-1:0]);
            r_sg  <= r_sg + SUM_W'(rd_data[2*CH_W-1:CH_W]);
            r_sr  <= r_sr + SUM_W'(rd_data[3*CH_W-1:2*CH_W]);
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_o_b  <= r_err ? '0 : div_res.q_blue;
            r_o_g  <= r_err ? '0 : div_res.q_green;
            r_o_r  <= r_err ? '0 : div_res.q_red;
            r_o_st <= r_err ? bbrgb_pkg::ST_OUTSIDE : bbrgb_pkg::ST_OK;
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.out_blue  = r_o_b;
    assign o_out.out_green = r_o_g;
    assign o_out.out_red   = r_o_r;
    assign o_out.status    = r_o_st;

endmodule

// ===== rtl/core/bbrgb_checker.sv =====
// ----------------------------------------------------------------------------
// bbrgb_checker
// Port-level checks of the RGB box blur core, bound to the top level.
// ----------------------------------------------------------------------------
module bbrgb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_in_operation,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [bbrgb_pkg::CHAN_W-1:0]  i_out_blue,
    input  logic [bbrgb_pkg::CHAN_W-1:0]  i_out_green,
    input  logic [bbrgb_pkg::CHAN_W-1:0]  i_out_red,
    input  logic                          i_out_status
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_blue) && $stable(i_out_green) && $stable(i_out_red)
             && $stable(i_out_status)))
        else $error("result payload changed while stalled");

    // an outside query reports zero channels
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status == bbrgb_pkg::ST_OUTSIDE)) |->
            ((i_out_blue == '0) && (i_out_green == '0) && (i_out_red == '0)))
        else $error("outside query with nonzero channels");

    // a query holds off the next request
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_operation == bbrgb_pkg::OP_QUERY))
            |=> !i_in_ready)
        else $error("request taken during a query");

    // a pixel write leaves the input ready
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_operation == bbrgb_pkg::OP_WRITE))
            |=> i_in_ready)
        else $error("pixel write stalled the input");

endmodule

bind box_blur_rgb_clipped_window_core bbrgb_checker u_bbrgb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_blue     (o_out.out_blue),
    .i_out_green    (o_out.out_green),
    .i_out_red      (o_out.out_red),
    .i_out_status   (o_out.status)
);

// ===== sim/blur_window_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_window_checker
// Watches the request, result and config channels of the RGB box blur core.
// It keeps its own copy of the frame store and of the registers. Every
// accepted query is turned into the expected window means and compared in
// order, field by field, against the results the core hands out.
// ----------------------------------------------------------------------------
module blur_window_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bbrgb_in_if   i_req_ch,
    bbrgb_out_if  i_res_ch,
    bbrgb_cfg_if  i_cfg_ch,
    output int    o_pending,
    output int    o_fail_count,
    output int    o_results_seen
);

    localparam int CHAN_W         = bbrgb_pkg::CHAN_W;
    localparam int POS_W          = bbrgb_pkg::POS_W;
    localparam int DIM_W          = bbrgb_pkg::DIM_W;
    localparam int KRAD_W         = bbrgb_pkg::KRAD_W;
    localparam int PIX_W          = bbrgb_pkg::PIX_W;
    localparam int MAX_WIDTH_DEF  = bbrgb_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT_DEF = bbrgb_pkg::MAX_HEIGHT_DEF;
    localparam int MAX_RADIUS_DEF = bbrgb_pkg::MAX_RADIUS_DEF;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              status;
    } t_window_mean;

    // shadow of the core's registers and frame store
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [KRAD_W-1:0] radius_reg;
    logic [PIX_W-1:0]  frame_mem [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];

    t_window_mean window_means_q[$];
    int           fail_cnt = 0;
    int           results_cnt = 0;

    assign o_fail_count   = fail_cnt;
    assign o_results_seen = results_cnt;

    initial begin
        for (int i = 0; i < MAX_WIDTH_DEF * MAX_HEIGHT_DEF; i++) begin
            frame_mem[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    task automatic check_field(input string name, input logic [CHAN_W-1:0] got,
                               input logic [CHAN_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%02h, expected 0x%02h",
                                      results_cnt, name, got, want));
        end
    endtask

    // zero reads as one, values beyond the store saturate
    function automatic int dim_in_use(input logic [DIM_W-1:0] v, input int lim);
        if (v == '0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    // truncated per-channel mean over the window clipped to the frame
    function automatic t_window_mean window_mean(input logic [POS_W-1:0] px,
                                                 input logic [POS_W-1:0] py);
        int           w, h, r, x0, x1, y0, y1, cnt;
        int unsigned  sum_b, sum_g, sum_r;
        logic [PIX_W-1:0] pix;
        t_window_mean res;
        w = dim_in_use(width_reg, MAX_WIDTH_DEF);
        h = dim_in_use(height_reg, MAX_HEIGHT_DEF);
        r = (int'(radius_reg) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius_reg);
        res = '0;
        if (int'(px) >= w || int'(py) >= h) begin
            res.status = bbrgb_pkg::ST_OUTSIDE;
            return res;
        end
        x0 = (int'(px) > r) ? int'(px) - r : 0;
        x1 = (int'(px) + r < w) ? int'(px) + r : w - 1;
        y0 = (int'(py) > r) ? int'(py) - r : 0;
        y1 = (int'(py) + r < h) ? int'(py) + r : h - 1;
        cnt = (x1 - x0 + 1) * (y1 - y0 + 1);
        sum_b = 0;
        sum_g = 0;
        sum_r = 0;
        for (int yy = y0; yy <= y1; yy++) begin
            for (int xx = x0; xx <= x1; xx++) begin
                pix = frame_mem[yy * MAX_WIDTH_DEF + xx];
                sum_b += pix[7:0];
                sum_g += pix[15:8];
                sum_r += pix[23:16];
            end
        end
        res.blue   = CHAN_W'(sum_b / cnt);
        res.green  = CHAN_W'(sum_g / cnt);
        res.red    = CHAN_W'(sum_r / cnt);
        res.status = bbrgb_pkg::ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_window_mean want;
        if (!i_rst_n) begin
            width_reg  = bbrgb_pkg::FRAME_DIM_RST;
            height_reg = bbrgb_pkg::FRAME_DIM_RST;
            radius_reg = bbrgb_pkg::RADIUS_RST;
            window_means_q.delete();
        end else begin
            // results first: a result never belongs to a query taken this cycle
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (window_means_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no query waiting",
                                              results_cnt));
                end else begin
                    want = window_means_q.pop_front();
                    check_field("blue", i_res_ch.out_blue, want.blue);
                    check_field("green", i_res_ch.out_green, want.green);
                    check_field("red", i_res_ch.out_red, want.red);
                    check_field("status", CHAN_W'(i_res_ch.status), CHAN_W'(want.status));
                end
                results_cnt++;
            end

            // register writes; unknown indexes are dropped
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                case (i_cfg_ch.index)
                    bbrgb_pkg::REG_FRAME_WIDTH:   width_reg  = i_cfg_ch.data;
                    bbrgb_pkg::REG_FRAME_HEIGHT:  height_reg = i_cfg_ch.data;
                    bbrgb_pkg::REG_KERNEL_RADIUS: radius_reg = i_cfg_ch.data[KRAD_W-1:0];
                    default: ;
                endcase
            end

            // pixel writes update the store, queries queue their expected means
            if (i_req_ch.valid && i_req_ch.ready) begin
                if (i_req_ch.operation == bbrgb_pkg::OP_WRITE) begin
                    frame_mem[{i_req_ch.pos_y, i_req_ch.pos_x}] =
                        {i_req_ch.in_red, i_req_ch.in_green, i_req_ch.in_blue};
                end else begin
                    window_means_q.push_back(window_mean(i_req_ch.pos_x, i_req_ch.pos_y));
                end
            end
        end
        o_pending <= window_means_q.size();
    end

endmodule

// ===== sim/box_blur_rgb_clipped_window_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_rgb_clipped_window_core_tb
// Top of the RGB box blur testbench.
// Drives pixel writes, window queries and register writes into the core,
// with bursty requests and a stalling receiver, and leaves the checking to
// the blur_window_checker next to the core and the assertions bound into the
// core. Queries are only sent once every pixel of their clipped window has been written.
// ----------------------------------------------------------------------------
module box_blur_rgb_clipped_window_core_tb;

    localparam int CHAN_W         = bbrgb_pkg::CHAN_W;
    localparam int POS_W          = bbrgb_pkg::POS_W;
    localparam int DIM_W          = bbrgb_pkg::DIM_W;
    localparam int KRAD_W         = bbrgb_pkg::KRAD_W;
    localparam int IDX_W          = bbrgb_pkg::IDX_W;
    localparam int MAX_WIDTH_DEF  = bbrgb_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT_DEF = bbrgb_pkg::MAX_HEIGHT_DEF;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 120;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES  = 40;
    localparam int LONG_HOLD    = 600;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    // receiver behavior
    typedef enum int {RX_EAGER, RX_BUSY, RX_SLOW} t_rx_mode;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pix_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    bbrgb_in_if  req_ch ();
    bbrgb_out_if res_ch ();
    bbrgb_cfg_if cfg_ch ();

    int pending;
    int fail_count;
    int results_seen;

    box_blur_rgb_clipped_window_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    blur_window_checker u_blur_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_ch       (req_ch),
        .i_res_ch       (res_ch),
        .i_cfg_ch       (cfg_ch),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_results_seen (results_seen)
    );

    // stimulus-side view of the frame in use and of written pixels
    bit pix_written [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
    int cur_w = MAX_WIDTH_DEF;
    int cur_h = MAX_HEIGHT_DEF;
    int cur_r = int'(bbrgb_pkg::RADIUS_RST);

    int n_sent     = 0;
    int n_writes   = 0;
    int n_queries  = 0;
    int n_outside  = 0;
    int n_settings = 0;
    int burst_left = 0;
    int hold_reqs  = 0;
    int cycle_cnt  = 0;

    function automatic logic [CHAN_W-1:0] chan_val();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return CHAN_W'($urandom);
    endfunction

    function automatic t_pix_req make_write(input int x, input int y, input int b,
                                            input int g, input int r);
        t_pix_req rq;
        rq.op    = bbrgb_pkg::OP_WRITE;
        rq.x     = POS_W'(x);
        rq.y     = POS_W'(y);
        rq.blue  = CHAN_W'(b);
        rq.green = CHAN_W'(g);
        rq.red   = CHAN_W'(r);
        return rq;
    endfunction

    // coordinate inside the frame; in wide frames stay near the ends so
    // that windows share their pixels
    function automatic int pick_in(input int dim);
        if (dim <= 16) return $urandom_range(0, dim - 1);
        if ($urandom_range(0, 1) == 1) return $urandom_range(0, 11);
        return dim - 1 - $urandom_range(0, 11);
    endfunction

    // one request; bursts of random length, random gaps between them
    task automatic send_req(input t_pix_req rq);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= rq.op;
        req_ch.pos_x     <= rq.x;
        req_ch.pos_y     <= rq.y;
        req_ch.in_blue   <= rq.blue;
        req_ch.in_green  <= rq.green;
        req_ch.in_red    <= rq.red;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n_sent++;
        if (rq.op == bbrgb_pkg::OP_WRITE) begin
            pix_written[int'(rq.y) * MAX_WIDTH_DEF + int'(rq.x)] = 1'b1;
            n_writes++;
        end else begin
            n_queries++;
            if (rq.x >= cur_w || rq.y >= cur_h) n_outside++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_ch.valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // query at (qx, qy), writing any missing pixel of its window first
    task automatic query_at(input int qx, input int qy);
        int x0, x1, y0, y1, xx, yy;
        t_pix_req rq;
        if (qx < cur_w && qy < cur_h) begin
            x0 = (qx > cur_r) ? qx - cur_r : 0;
            x1 = (qx + cur_r < cur_w) ? qx + cur_r : cur_w - 1;
            y0 = (qy > cur_r) ? qy - cur_r : 0;
            y1 = (qy + cur_r < cur_h) ? qy + cur_r : cur_h - 1;
            for (yy = y0; yy <= y1; yy++) begin
                for (xx = x0; xx <= x1; xx++) begin
                    if (!pix_written[yy * MAX_WIDTH_DEF + xx]) begin
                        send_req(make_write(xx, yy, chan_val(), chan_val(), chan_val()));
                    end
                end
            end
        end
        rq       = make_write(qx, qy, $urandom, $urandom, $urandom);
        rq.op    = bbrgb_pkg::OP_QUERY;
        send_req(rq);
    endtask

    // stop sending until every query has been answered and the core is idle
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            bbrgb_pkg::REG_FRAME_WIDTH:
                cur_w = (val == '0) ? 1 : ((int'(val) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF
                                                                      : int'(val));
            bbrgb_pkg::REG_FRAME_HEIGHT:
                cur_h = (val == '0) ? 1 : ((int'(val) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF
                                                                       : int'(val));
            bbrgb_pkg::REG_KERNEL_RADIUS:
                cur_r = int'(val[KRAD_W-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // new frame setting, written only once the core has gone idle
    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [DIM_W-1:0] r);
        settle();
        write_cfg(bbrgb_pkg::REG_FRAME_WIDTH, w);
        write_cfg(bbrgb_pkg::REG_FRAME_HEIGHT, h);
        write_cfg(bbrgb_pkg::REG_KERNEL_RADIUS, r);
        if ($urandom_range(0, 2) == 0) write_cfg(REG_SPARE, DIM_W'($urandom));
        n_settings++;
    endtask

    // mixed writes, outside queries and window queries
    task automatic random_phase(input int budget);
        int start, roll, qx, qy;
        start = n_sent;
        while (n_sent - start < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                if ($urandom_range(0, 9) < 6) begin
                    qx = pick_in(cur_w);
                    qy = pick_in(cur_h);
                end else begin
                    qx = $urandom_range(0, 255);
                    qy = $urandom_range(0, 255);
                end
                send_req(make_write(qx, qy, chan_val(), chan_val(), chan_val()));
            end else if (roll < 42 && (cur_w < MAX_WIDTH_DEF || cur_h < MAX_HEIGHT_DEF)) begin
                if (cur_w < MAX_WIDTH_DEF && (cur_h == MAX_HEIGHT_DEF
                                              || $urandom_range(0, 1) == 1)) begin
                    qx = $urandom_range(cur_w, 255);
                    qy = $urandom_range(0, 255);
                end else begin
                    qx = $urandom_range(0, 255);
                    qy = $urandom_range(cur_h, 255);
                end
                query_at(qx, qy);
            end else begin
                query_at(pick_in(cur_w), pick_in(cur_h));
            end
        end
    endtask

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles with %0d queries unanswered", cycle_cnt, pending);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: changing ready pattern, plus one long hold-off on request
    initial begin
        int       hold_left, mode_left, hold_seen;
        t_rx_mode mode;
        hold_left = 0;
        mode_left = 0;
        hold_seen = 0;
        mode      = RX_EAGER;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(30, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_EAGER: res_ch.ready <= 1'b1;
                    RX_BUSY:  res_ch.ready <= ($urandom_range(0, 99) < 70);
                    default:  res_ch.ready <= ($urandom_range(0, 99) < 30);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int kind, w_val, h_val;
        logic [DIM_W-1:0] r_val;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= bbrgb_pkg::OP_WRITE;
        req_ch.pos_x     <= '0;
        req_ch.pos_y     <= '0;
        req_ch.in_blue   <= '0;
        req_ch.in_green  <= '0;
        req_ch.in_red    <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= bbrgb_pkg::REG_FRAME_WIDTH;
        cfg_ch.data      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner pixels with extreme values, reset setting
        send_req(make_write(0, 0, 8'h00, 8'h00, 8'h00));
        send_req(make_write(255, 255, 8'hFF, 8'hFF, 8'hFF));
        send_req(make_write(255, 0, 8'hFF, 8'h00, 8'h80));
        send_req(make_write(0, 255, 8'h01, 8'h7F, 8'hFE));

        // full frame, radius zero: each query returns its own pixel
        set_frame(9'd256, 9'd256, 9'd0);
        query_at(0, 0);
        query_at(255, 255);
        query_at(255, 0);
        query_at(0, 255);

        // one-pixel frame, largest radius, queries on the pixel and outside the frame
        set_frame(9'd1, 9'd1, 9'd31);
        query_at(0, 0);
        query_at(1, 0);
        query_at(0, 1);
        query_at(255, 255);

        // width zero reads as one, height saturates, radius takes the low bits
        set_frame(9'd0, 9'h1FF, 9'h1E0);
        query_at(0, 255);
        query_at(3, 7);

        // tiny frame: windows clipped on every side
        set_frame(9'd3, 9'd2, 9'd1);
        query_at(0, 0);
        query_at(2, 1);
        query_at(1, 0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            kind = ph % 3;
            if (kind == 0) begin
                w_val = $urandom_range(1, 12);
                h_val = $urandom_range(1, 12);
                r_val = DIM_W'($urandom);
            end else if (kind == 1) begin
                w_val = $urandom_range(0, 3);
                h_val = $urandom_range(1, 40);
                r_val = DIM_W'($urandom);
                if (ph > 2) begin
                    h_val = w_val;
                    w_val = $urandom_range(1, 40);
                end
            end else begin
                w_val = $urandom_range(13, 511);
                h_val = $urandom_range(13, 511);
                r_val = {4'($urandom), 5'($urandom_range(0, 1))};
            end
            set_frame(DIM_W'(w_val), DIM_W'(h_val), r_val);
            random_phase(RANDOM_ITEMS / RANDOM_PHASES);

            // back pressure: receiver holds off while queries keep coming
            if (ph == 2) begin
                set_frame(9'd4, 9'd4, 9'd1);
                for (int yy = 0; yy < 4; yy++) begin
                    for (int xx = 0; xx < 4; xx++) begin
                        if (!pix_written[yy * MAX_WIDTH_DEF + xx]) begin
                            send_req(make_write(xx, yy, chan_val(), chan_val(), chan_val()));
                        end
                    end
                end
                hold_reqs <= hold_reqs + 1;
                burst_left = 30;
                for (int k = 0; k < 12; k++) begin
                    query_at($urandom_range(0, 3), $urandom_range(0, 3));
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixel writes and %0d window queries (%0d outside the frame)",
                 n_writes, n_queries, n_outside);
        $display("over %0d frame settings; %0d results checked in %0d cycles",
                 n_settings, results_seen, cycle_cnt);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bbrgb_pkg.sv
rtl/core/bbrgb_if.sv
rtl/core/bbrgb_store.sv
rtl/core/bbrgb_div.sv
rtl/core/box_blur_rgb_clipped_window_core.sv
rtl/core/bbrgb_checker.sv
sim/blur_window_checker.sv
sim/box_blur_rgb_clipped_window_core_tb.sv
